### rtl/core/nmcs_pkg.sv
package nmcs_pkg;

  localparam int CH_W   = 8;
  localparam int SQ_W   = 16;
  localparam int RAD_W  = 30;
  localparam int ROOT_W = 15;
  localparam int REM_W  = 17;
  localparam int NCELL  = ROOT_W;

  localparam logic [SQ_W-1:0] UNIT_SQ   = 16'd65025;
  localparam logic [13:0]     Z_SCALE   = 14'd16129;
  localparam logic [15:0]     RECIP_255 = 16'h8081;
  localparam int              RECIP_SH  = 23;
  localparam logic [CH_W-1:0] Z_BIAS    = 8'd127;
  localparam logic [CH_W-1:0] CH_FULL   = 8'd255;

  localparam logic [2:0] ADDR_MODE = 3'd0;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_SWZ   = 2'd1,
    MODE_DESWZ = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;
    logic            rebuild;
  } pix_t;

endpackage

### rtl/core/nmcs_root_cell.sv
module nmcs_root_cell
  import nmcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  pix_t              up_pix,
  input  logic [REM_W-1:0]  up_rem,
  input  logic [ROOT_W-1:0] up_root,
  input  logic [RAD_W-1:0]  up_rad,
  output logic              dn_valid,
  input  logic              dn_ready,
  output pix_t              dn_pix,
  output logic [REM_W-1:0]  dn_rem,
  output logic [ROOT_W-1:0] dn_root,
  output logic [RAD_W-1:0]  dn_rad
);

  logic              valid_r;
  pix_t              pix_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RAD_W-1:0]  rad_r;

  logic [REM_W+1:0]  rem_ext;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [RAD_W-1:0]  rad_nxt;

  // one root bit per cell: bring down two radicand bits, try 4q+1
  always_comb begin
    rem_ext  = {up_rem, up_rad[RAD_W-1 -: 2]};
    trial    = {2'b00, up_root, 2'b01};
    diff     = rem_ext - trial;
    ge       = (rem_ext >= trial);
    rem_nxt  = ge ? diff[REM_W-1:0] : rem_ext[REM_W-1:0];
    root_nxt = {up_root[ROOT_W-2:0], ge};
    rad_nxt  = {up_rad[RAD_W-3:0], 2'b00};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_r  <= up_pix;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_pix   = pix_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_rad   = rad_r;

endmodule

### rtl/core/normal_map_channel_swizzle.sv
// channel   dir  item / payload
// --------  ---  -------------------------------------------------------
// in_       in   tdata {alpha, blue, green, red} bytes, tlast end of image
// out_      out  tdata {alpha, blue, green, red} bytes, tlast end of image
// cfg_      in   APB, swizzle_mode at byte address 0
//
// One item per cycle while the output is not stalled; 2 prep stages, 15 root cells, output.
// The pipeline depth is set by the root chain: one cell per bit of the 15-bit root.
// Each stage holds its item until the next frees up, so a stalled output
// fills the chain before in_tready drops; bubbles are squeezed out.
// rst_n is synchronous; it clears the stage valids and swizzle_mode.
module normal_map_channel_swizzle
  import nmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red, green, blue, alpha
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0] mode_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_MODE) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  // stage 0: channel routing and squares of the normal's x and y
  logic [CH_W-1:0] in_r, in_g, in_b, in_a;
  pix_t            pix0_nxt;
  logic signed [9:0] xs, ys;
  logic signed [19:0] xs_sq, ys_sq;

  assign in_r = in_tdata[7:0];
  assign in_g = in_tdata[15:8];
  assign in_b = in_tdata[23:16];
  assign in_a = in_tdata[31:24];

  always_comb begin
    pix0_nxt = '{red: in_r, green: in_g, blue: in_b, alpha: in_a,
                 last: in_tlast, rebuild: 1'b0};
    case (mode_r)
      MODE_SWZ: begin
        pix0_nxt.red   = CH_FULL;
        pix0_nxt.blue  = in_a;
        pix0_nxt.alpha = in_r;
      end
      MODE_DESWZ: begin
        pix0_nxt.red     = in_a;
        pix0_nxt.alpha   = in_b;
        pix0_nxt.rebuild = 1'b1;
      end
      default: begin
      end
    endcase
    xs    = $signed({1'b0, in_a, 1'b0}) - 10'sd255;
    ys    = $signed({1'b0, in_g, 1'b0}) - 10'sd255;
    xs_sq = xs * xs;
    ys_sq = ys * ys;
  end

  logic            s0_valid_r, s0_ready;
  pix_t            s0_pix_r;
  logic [SQ_W-1:0] s0_xsq_r, s0_ysq_r;

  logic            s1_valid_r, s1_ready;
  pix_t            s1_pix_r;
  logic [RAD_W-1:0] s1_rad_r;

  logic [SQ_W:0]    sq_sum;
  logic [SQ_W-1:0]  r_clamp;
  logic [RAD_W-1:0] rad_nxt;

  logic              cv   [0:NCELL];
  logic              crdy [0:NCELL];
  pix_t              cpix [0:NCELL];
  logic [REM_W-1:0]  crem [0:NCELL];
  logic [ROOT_W-1:0] croot[0:NCELL];
  logic [RAD_W-1:0]  crad [0:NCELL];

  assign in_tready = s0_ready;
  assign s0_ready  = !s0_valid_r || s1_ready;
  assign s1_ready  = !s1_valid_r || crdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_r <= in_tvalid;
      if (s1_ready) s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_tvalid) begin
      s0_pix_r <= pix0_nxt;
      s0_xsq_r <= xs_sq[SQ_W-1:0];
      s0_ysq_r <= ys_sq[SQ_W-1:0];
    end
  end

  // stage 1: r = 1 - x^2 - y^2 in units of 1/255^2 clamped at zero, scaled by 127^2
  always_comb begin
    sq_sum  = {1'b0, s0_xsq_r} + {1'b0, s0_ysq_r};
    r_clamp = (sq_sum > {1'b0, UNIT_SQ}) ? '0 : UNIT_SQ - sq_sum[SQ_W-1:0];
    rad_nxt = r_clamp * Z_SCALE;
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s0_valid_r) begin
      s1_pix_r <= s0_pix_r;
      s1_rad_r <= rad_nxt;
    end
  end

  assign cv[0]    = s1_valid_r;
  assign cpix[0]  = s1_pix_r;
  assign crem[0]  = '0;
  assign croot[0] = '0;
  assign crad[0]  = s1_rad_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    nmcs_root_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_ready (crdy[i]),
      .up_pix   (cpix[i]),
      .up_rem   (crem[i]),
      .up_root  (croot[i]),
      .up_rad   (crad[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (crdy[i+1]),
      .dn_pix   (cpix[i+1]),
      .dn_rem   (crem[i+1]),
      .dn_root  (croot[i+1]),
      .dn_rad   (crad[i+1])
    );
  end

  // output stage: z = 127 + root/255, divide by reciprocal multiply
  logic        out_valid_r;
  pix_t        out_pix_r;
  logic [30:0] quot_prod;
  logic [CH_W-1:0] z_byte;
  pix_t        out_pix_nxt;

  assign crdy[NCELL] = !out_valid_r || out_tready;

  always_comb begin
    quot_prod   = croot[NCELL] * RECIP_255;
    z_byte      = Z_BIAS + quot_prod[RECIP_SH +: CH_W];
    out_pix_nxt = cpix[NCELL];
    if (cpix[NCELL].rebuild) begin
      out_pix_nxt.blue = z_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (crdy[NCELL]) begin
      out_valid_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (crdy[NCELL] && cv[NCELL]) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r.alpha, out_pix_r.blue, out_pix_r.green, out_pix_r.red};
  assign out_tlast  = out_pix_r.last;

`ifndef SYNTH
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s0_valid_r && s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled while chain has room");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pix_r.rebuild |->
      out_pix_r.blue >= Z_BIAS && out_pix_r.blue <= 8'd253)
    else $error("rebuilt z out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_pix_r))
    else $error("output item changed under stall");
`endif

endmodule
